### rtl/eac_pkg.sv
// Shared constants for the encoder electric angle compensation block.
package eac_pkg;

  // Angle format: unsigned fraction of one turn
  localparam int ANGLE_W = 16;
  // Interpolation weight bits taken from the table position fraction
  localparam int FRAC_W = 8;
  // Correction table entry width (signed)
  localparam int CORR_W = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PP_W       = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLE_PAIRS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_DIR  = 2'd2;

  localparam logic [PP_W-1:0] POLE_PAIRS_RST = 7'd7;

  // Item operation codes
  localparam logic OP_COMPUTE = 1'b0;
  localparam logic OP_WRITE   = 1'b1;

  // Correction table write request
  typedef struct packed {
    logic                     en;
    logic [11:0]              addr;
    logic signed [CORR_W-1:0] data;
  } tbl_wr_t;

endpackage

### rtl/encoder_electric_angle_comp_top.sv
// Top level: encoder offset removal, electric angle and table-interpolated compensation.
//
//  channel   direction  handshake            payload
//  in_       input      in_valid / in_stall  op, encoder_angle, table_index, table_value
//  out_      output     out_valid/out_stall  mech_angle, elec_angle_raw, elec_angle_comp
//  cfg_      input      cfg_wr_en            cfg_index, cfg_wdata
//
// One item per cycle while in_stall is low. A compute item is registered with its
// table reads in the read stage and then moves to the output register, so it
// passes both registers before out_valid shows it; write items give none.
// After reset the table is swept to zero, one entry a cycle, and in_stall stays
// high until the sweep is done. Configuration writes are taken at any time.
// A stalled result holds in the output register while one more item waits in the
// read stage; in_stall rises only when both are blocked or the sweep is running.
module encoder_electric_angle_comp_top #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic [eac_pkg::ANGLE_W-1:0]         in_encoder_angle,
  input  logic [7:0]                          in_table_index,
  input  logic signed [eac_pkg::CORR_W-1:0]   in_table_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [eac_pkg::ANGLE_W-1:0]         out_mech_angle,
  output logic [eac_pkg::ANGLE_W-1:0]         out_elec_angle_raw,
  output logic [eac_pkg::ANGLE_W-1:0]         out_elec_angle_comp,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [eac_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [eac_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int IDX_W = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int POS_W = eac_pkg::ANGLE_W + $clog2(TABLE_ENTRIES + 1);
  localparam int AW    = eac_pkg::ANGLE_W;
  localparam int FW    = eac_pkg::FRAC_W;
  localparam int CW    = eac_pkg::CORR_W;
  localparam int ACC_W = CW + FW + 2;

  // Configuration registers
  logic [AW-1:0]            offset_r;
  logic [eac_pkg::PP_W-1:0] pole_pairs_r;
  logic                     reverse_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r     <= '0;
      pole_pairs_r <= eac_pkg::POLE_PAIRS_RST;
      reverse_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        eac_pkg::CFG_ANGLE_OFFSET: offset_r     <= cfg_wdata[AW-1:0];
        eac_pkg::CFG_POLE_PAIRS:   pole_pairs_r <= cfg_wdata[eac_pkg::PP_W-1:0];
        eac_pkg::CFG_REVERSE_DIR:  reverse_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Handshake and stage control
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_load;
  logic clr_busy;
  logic in_accept, cmp_accept;

  assign out_load   = !out_valid_r || !out_stall;
  assign in_stall   = clr_busy || (s1_valid_r && !out_load);
  assign in_accept  = in_valid && !in_stall;
  assign cmp_accept = in_accept && (in_op == eac_pkg::OP_COMPUTE);

  // Front end: offset, table position, electric angle
  logic [AW-1:0]    mech;
  logic [POS_W-1:0] pos;
  logic [IDX_W-1:0] i0, i1;
  logic [FW-1:0]    frac;
  logic [AW-1:0]    elec;
  logic [AW+eac_pkg::PP_W-1:0] elec_prod;

  always_comb begin
    mech      = in_encoder_angle - offset_r;
    pos       = POS_W'(mech) * POS_W'(TABLE_ENTRIES);
    i0        = pos[AW +: IDX_W];
    i1        = (i0 == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : i0 + 1'b1;
    frac      = pos[AW-1 -: FW];
    elec_prod = (AW + eac_pkg::PP_W)'(mech) * (AW + eac_pkg::PP_W)'(pole_pairs_r);
    elec      = reverse_r ? (AW)'(-elec_prod[AW-1:0]) : elec_prod[AW-1:0];
  end

  // Table write requests
  eac_pkg::tbl_wr_t tbl_wr;

  always_comb begin
    tbl_wr.en   = in_accept && (in_op == eac_pkg::OP_WRITE) &&
                  (32'(in_table_index) < TABLE_ENTRIES);
    tbl_wr.addr = 12'(in_table_index);
    tbl_wr.data = in_table_value;
  end

  logic signed [CW-1:0] e0, e1;

  eac_corr_table #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (tbl_wr),
    .rd_en    (cmp_accept),
    .rd_addr0 (i0),
    .rd_addr1 (i1),
    .rd_data0 (e0),
    .rd_data1 (e1),
    .clr_busy (clr_busy)
  );

  // Read stage registers
  logic [AW-1:0] mech_s1_r, elec_s1_r;
  logic [FW-1:0] frac_s1_r;

  always_ff @(posedge clk) begin
    if (cmp_accept) begin
      mech_s1_r <= mech;
      elec_s1_r <= elec;
      frac_s1_r <= frac;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (cmp_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_valid_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_load) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Linear interpolation between neighbor entries, floor of sum / 256
  logic [FW:0]             w0;
  logic signed [ACC_W-1:0] p0, p1, acc;
  logic [CW-1:0]           corr;
  logic [AW-1:0]           comp;

  always_comb begin
    w0   = (FW + 1)'(1 << FW) - {1'b0, frac_s1_r};
    p0   = ACC_W'(e0) * ACC_W'(signed'({1'b0, w0}));
    p1   = ACC_W'(e1) * ACC_W'(signed'({2'b00, frac_s1_r}));
    acc  = p0 + p1;
    corr = acc[FW +: CW];
    comp = elec_s1_r + AW'(corr);
  end

  // Output register
  logic [AW-1:0] out_mech_r, out_raw_r, out_comp_r;

  always_ff @(posedge clk) begin
    if (s1_valid_r && out_load) begin
      out_mech_r <= mech_s1_r;
      out_raw_r  <= elec_s1_r;
      out_comp_r <= comp;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_mech_angle      = out_mech_r;
  assign out_elec_angle_raw  = out_raw_r;
  assign out_elec_angle_comp = out_comp_r;

  // Checks
  a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !s1_valid_r)
    else $error("read stage occupied during table clear");

  a_s1_holds_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_load) |=> (s1_valid_r && $stable(mech_s1_r) && $stable(elec_s1_r)))
    else $error("read stage lost its item while the output was blocked");

  a_write_gives_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_op == eac_pkg::OP_WRITE) && !s1_valid_r) |=> !s1_valid_r)
    else $error("table write item entered the result path");

endmodule

### rtl/eac_corr_table.sv
// Correction table memory: one write port, two registered read ports, clear sweep after reset.
module eac_corr_table #(
  parameter int ENTRIES = 256,
  parameter int IDX_W   = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  eac_pkg::tbl_wr_t                  wr,
  input  logic                              rd_en,
  input  logic [IDX_W-1:0]                  rd_addr0,
  input  logic [IDX_W-1:0]                  rd_addr1,
  output logic signed [eac_pkg::CORR_W-1:0] rd_data0,
  output logic signed [eac_pkg::CORR_W-1:0] rd_data1,
  output logic                              clr_busy
);

  logic signed [eac_pkg::CORR_W-1:0] mem [ENTRIES];

  logic             clr_busy_r;
  logic [IDX_W-1:0] clr_idx_r;

  logic                              we;
  logic [IDX_W-1:0]                  wa;
  logic signed [eac_pkg::CORR_W-1:0] wd;

  // Clear sweep: one entry per cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == IDX_W'(ENTRIES - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Write port shared by the sweep and table write items
  always_comb begin
    if (clr_busy_r) begin
      we = 1'b1;
      wa = clr_idx_r;
      wd = '0;
    end else begin
      we = wr.en;
      wa = IDX_W'(wr.addr);
      wd = wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
  end

  assign clr_busy = clr_busy_r;

endmodule
